// File: src/dqpi_pkg.sv
`timescale 1ns / 1ps

package dqpi_pkg;

  localparam int DATA_W  = 32;
  localparam int GAIN_W  = 31;
  localparam int ERR_W   = DATA_W + 1;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 64;
  localparam int PTERM_W = PROD_W - 16;
  localparam int SUM_W   = PTERM_W + 1;
  localparam int IDX_W   = 3;

  typedef logic signed [DATA_W-1:0]  q16_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic        [GAIN_W-1:0]  gain_t;
  typedef logic signed [MUL_W-1:0]   mul_op_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [PTERM_W-1:0] pterm_t;

  localparam logic [IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd2;
  localparam logic [IDX_W-1:0] REG_VOLT_LIMIT    = 3'd3;
  localparam logic [IDX_W-1:0] REG_Q_CURRENT_REF = 3'd4;

  localparam gain_t               PROP_GAIN_RST     = 31'd65536;
  localparam gain_t               INTEG_GAIN_RST    = 31'd0;
  localparam logic [DATA_W-1:0]   SAMPLE_PERIOD_RST = 32'd429497;
  localparam gain_t               VOLT_LIMIT_RST    = 31'h7FFF_FFFF;
  localparam q16_t                Q_CURRENT_REF_RST = 32'sd0;

endpackage

// File: src/dqpi_in_if.sv
`timescale 1ns / 1ps

interface dqpi_in_if;
  logic            valid;
  logic            ready;
  dqpi_pkg::q16_t  d_current_ref;
  dqpi_pkg::q16_t  d_current_meas;
  dqpi_pkg::q16_t  q_current_meas;
  dqpi_pkg::q16_t  d_volt_feedfwd;
  dqpi_pkg::q16_t  q_volt_feedfwd;

  modport source (
    output valid, d_current_ref, d_current_meas, q_current_meas,
           d_volt_feedfwd, q_volt_feedfwd,
    input  ready
  );
  modport sink (
    input  valid, d_current_ref, d_current_meas, q_current_meas,
           d_volt_feedfwd, q_volt_feedfwd,
    output ready
  );
endinterface

// File: src/dqpi_out_if.sv
`timescale 1ns / 1ps

interface dqpi_out_if;
  logic            valid;
  logic            ready;
  dqpi_pkg::q16_t  d_volt_cmd;
  dqpi_pkg::q16_t  q_volt_cmd;
  dqpi_pkg::q16_t  d_correction;
  dqpi_pkg::q16_t  q_correction;

  modport source (
    output valid, d_volt_cmd, q_volt_cmd, d_correction, q_correction,
    input  ready
  );
  modport sink (
    input  valid, d_volt_cmd, q_volt_cmd, d_correction, q_correction,
    output ready
  );
endinterface

// File: src/dqpi_mul.sv
`timescale 1ns / 1ps

module dqpi_mul (
  input  logic              clk,
  input  dqpi_pkg::mul_op_t a,
  input  dqpi_pkg::mul_op_t b,
  output dqpi_pkg::prod_t   p
);

  logic signed [2*dqpi_pkg::MUL_W-1:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    p <= full[dqpi_pkg::PROD_W-1:0];
  end

endmodule

// File: src/dqpi_clamp.sv
`timescale 1ns / 1ps

module dqpi_clamp (
  input  dqpi_pkg::pterm_t a,
  input  dqpi_pkg::q16_t   b,
  input  dqpi_pkg::gain_t  lim,
  output dqpi_pkg::q16_t   y
);

  logic signed [dqpi_pkg::SUM_W-1:0] sum;
  logic signed [dqpi_pkg::SUM_W-1:0] pos_lim;
  logic signed [dqpi_pkg::SUM_W-1:0] neg_lim;

  always_comb begin
    sum     = {a[dqpi_pkg::PTERM_W-1], a}
            + {{(dqpi_pkg::SUM_W-dqpi_pkg::DATA_W){b[dqpi_pkg::DATA_W-1]}}, b};
    pos_lim = {{(dqpi_pkg::SUM_W-dqpi_pkg::GAIN_W){1'b0}}, lim};
    neg_lim = -pos_lim;
    if (sum > pos_lim) begin
      y = pos_lim[dqpi_pkg::DATA_W-1:0];
    end else if (sum < neg_lim) begin
      y = neg_lim[dqpi_pkg::DATA_W-1:0];
    end else begin
      y = sum[dqpi_pkg::DATA_W-1:0];
    end
  end

endmodule

// File: src/dq_pi_current_controller_unit.sv
`timescale 1ns / 1ps
// dq PI current regulator with voltage feedforward, signed Q16.16.
// samples: valid/ready channel carrying the d reference, d and q measured
//   currents and d and q feedforward voltages. One transfer per control period.
// results: valid/ready channel carrying d and q voltage commands and the
//   clamped d and q PI corrections. Exactly one result per sample.
// cfg_wen/cfg_index/cfg_data: register writes (Kp, Ki, Ts, limit, q reference);
//   the user must issue them only while no sample is in flight (the block has no check).
// After a sample transfer the sequencer steps through KP_D, KI_D, INT_D,
//   COR_D, INT_Q, COR_Q and DONE, and the result is loaded into the output
//   register from DONE. No new sample is taken before that, as the single
//   shared 33x33 multiplier performs Ki*Ts, Kp*err and KiTs*err for both
//   axes in turn, with one add-and-clamp unit following it.
// samples.ready is high only while the sequencer is idle and out of reset.
// A stalled receiver holds the result register; a finished sample waits in
//   the last step until the register is free, then the block reopens.
// Reset (rst, synchronous) restores the register defaults, zeroes both
//   integrators and drops any pending result.
module dq_pi_current_controller_unit (
  input  logic                          clk,
  input  logic                          rst,
  dqpi_in_if.sink                       samples,
  dqpi_out_if.source                    results,
  input  logic                          cfg_wen,
  input  logic [dqpi_pkg::IDX_W-1:0]    cfg_index,
  input  logic [dqpi_pkg::DATA_W-1:0]   cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_KP_D  = 3'd1;
  localparam logic [2:0] ST_KI_D  = 3'd2;
  localparam logic [2:0] ST_INT_D = 3'd3;
  localparam logic [2:0] ST_COR_D = 3'd4;
  localparam logic [2:0] ST_INT_Q = 3'd5;
  localparam logic [2:0] ST_COR_Q = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]                   state;
  dqpi_pkg::gain_t              prop_gain;
  dqpi_pkg::gain_t              integ_gain;
  logic [dqpi_pkg::DATA_W-1:0]  sample_period;
  dqpi_pkg::gain_t              volt_limit;
  dqpi_pkg::q16_t               q_current_ref;

  dqpi_pkg::err_t    err_d;
  dqpi_pkg::err_t    err_q;
  dqpi_pkg::q16_t    ff_d;
  dqpi_pkg::q16_t    ff_q;
  dqpi_pkg::gain_t   kits;
  dqpi_pkg::pterm_t  pterm;
  dqpi_pkg::q16_t    integ_d;
  dqpi_pkg::q16_t    integ_q;
  dqpi_pkg::q16_t    corr_d;
  dqpi_pkg::q16_t    corr_q;

  dqpi_pkg::mul_op_t mul_a;
  dqpi_pkg::mul_op_t mul_b;
  dqpi_pkg::prod_t   prod;
  dqpi_pkg::pterm_t  prod_q16;
  dqpi_pkg::pterm_t  clamp_a;
  dqpi_pkg::q16_t    clamp_b;
  dqpi_pkg::q16_t    clamp_y;

  logic signed [dqpi_pkg::DATA_W:0] cmd_d_sum;
  logic signed [dqpi_pkg::DATA_W:0] cmd_q_sum;
  dqpi_pkg::q16_t    cmd_d;
  dqpi_pkg::q16_t    cmd_q;

  logic accept;
  logic out_free;

  assign samples.ready = (state == ST_IDLE) && !rst;
  assign accept        = samples.valid && samples.ready;
  assign out_free      = !results.valid || results.ready;
  assign prod_q16      = prod[dqpi_pkg::PROD_W-1:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= dqpi_pkg::PROP_GAIN_RST;
      integ_gain    <= dqpi_pkg::INTEG_GAIN_RST;
      sample_period <= dqpi_pkg::SAMPLE_PERIOD_RST;
      volt_limit    <= dqpi_pkg::VOLT_LIMIT_RST;
      q_current_ref <= dqpi_pkg::Q_CURRENT_REF_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        dqpi_pkg::REG_PROP_GAIN:     prop_gain     <= cfg_data[dqpi_pkg::GAIN_W-1:0];
        dqpi_pkg::REG_INTEG_GAIN:    integ_gain    <= cfg_data[dqpi_pkg::GAIN_W-1:0];
        dqpi_pkg::REG_SAMPLE_PERIOD: sample_period <= cfg_data;
        dqpi_pkg::REG_VOLT_LIMIT:    volt_limit    <= cfg_data[dqpi_pkg::GAIN_W-1:0];
        dqpi_pkg::REG_Q_CURRENT_REF: q_current_ref <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (state)
      ST_IDLE: begin
        mul_a = {2'b00, integ_gain};
        mul_b = {1'b0, sample_period};
      end
      ST_KP_D: begin
        mul_a = {2'b00, prop_gain};
        mul_b = err_d;
      end
      ST_KI_D: begin
        mul_a = {2'b00, kits};
        mul_b = err_d;
      end
      ST_INT_D: begin
        mul_a = {2'b00, prop_gain};
        mul_b = err_q;
      end
      ST_COR_D: begin
        mul_a = {2'b00, kits};
        mul_b = err_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  dqpi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign clamp_a = (state == ST_INT_D || state == ST_INT_Q) ? prod_q16 : pterm;
  assign clamp_b = (state == ST_INT_D || state == ST_COR_D) ? integ_d : integ_q;

  dqpi_clamp u_clamp (
    .a   (clamp_a),
    .b   (clamp_b),
    .lim (volt_limit),
    .y   (clamp_y)
  );

  always_comb begin
    cmd_d_sum = {ff_d[dqpi_pkg::DATA_W-1], ff_d} + {corr_d[dqpi_pkg::DATA_W-1], corr_d};
    cmd_q_sum = {ff_q[dqpi_pkg::DATA_W-1], ff_q} + {corr_q[dqpi_pkg::DATA_W-1], corr_q};
    if (cmd_d_sum[dqpi_pkg::DATA_W] != cmd_d_sum[dqpi_pkg::DATA_W-1]) begin
      cmd_d = {cmd_d_sum[dqpi_pkg::DATA_W], {(dqpi_pkg::DATA_W-1){~cmd_d_sum[dqpi_pkg::DATA_W]}}};
    end else begin
      cmd_d = cmd_d_sum[dqpi_pkg::DATA_W-1:0];
    end
    if (cmd_q_sum[dqpi_pkg::DATA_W] != cmd_q_sum[dqpi_pkg::DATA_W-1]) begin
      cmd_q = {cmd_q_sum[dqpi_pkg::DATA_W], {(dqpi_pkg::DATA_W-1){~cmd_q_sum[dqpi_pkg::DATA_W]}}};
    end else begin
      cmd_q = cmd_q_sum[dqpi_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      integ_d       <= '0;
      integ_q       <= '0;
      results.valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_KP_D;
          end
        end
        ST_KP_D: begin
          kits  <= prod[dqpi_pkg::PROD_W-2:32];
          state <= ST_KI_D;
        end
        ST_KI_D: begin
          pterm <= prod_q16;
          state <= ST_INT_D;
        end
        ST_INT_D: begin
          integ_d <= clamp_y;
          state   <= ST_COR_D;
        end
        ST_COR_D: begin
          corr_d <= clamp_y;
          pterm  <= prod_q16;
          state  <= ST_INT_Q;
        end
        ST_INT_Q: begin
          integ_q <= clamp_y;
          state   <= ST_COR_Q;
        end
        ST_COR_Q: begin
          corr_q <= clamp_y;
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_d <= {samples.d_current_ref[dqpi_pkg::DATA_W-1], samples.d_current_ref}
             - {samples.d_current_meas[dqpi_pkg::DATA_W-1], samples.d_current_meas};
      err_q <= {q_current_ref[dqpi_pkg::DATA_W-1], q_current_ref}
             - {samples.q_current_meas[dqpi_pkg::DATA_W-1], samples.q_current_meas};
      ff_d  <= samples.d_volt_feedfwd;
      ff_q  <= samples.q_volt_feedfwd;
    end
    if (state == ST_DONE && out_free) begin
      results.d_volt_cmd   <= cmd_d;
      results.q_volt_cmd   <= cmd_q;
      results.d_correction <= corr_d;
      results.q_correction <= corr_q;
    end
  end

endmodule

// File: src/dqpi_checker.sv
`timescale 1ns / 1ps

module dqpi_checker (
  input logic           clk,
  input logic           rst,
  input logic           samples_valid,
  input logic           samples_ready,
  input logic           results_valid,
  input logic           results_ready,
  input dqpi_pkg::q16_t results_d_volt_cmd,
  input dqpi_pkg::q16_t results_q_correction
);

  logic in_xfer;

  assign in_xfer = samples_valid && samples_ready;

  // busy right after a sample is taken
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !samples_ready)
    else $error("samples.ready high right after a transfer");

  // each rise of results_valid must match an earlier sample transfer
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(results_valid) |-> $past(in_xfer, 8))
    else $error("result appeared without a matching sample");

  // never take a sample while the previous one is still in KP_D to COR_D
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_xfer ##1 !in_xfer ##1 !in_xfer ##1 !in_xfer)
    else $error("sample taken while busy");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=>
      results_valid && $stable(results_d_volt_cmd) && $stable(results_q_correction))
    else $error("stalled result changed");

endmodule

bind dq_pi_current_controller_unit dqpi_checker u_dqpi_checker (
  .clk                  (clk),
  .rst                  (rst),
  .samples_valid        (samples.valid),
  .samples_ready        (samples.ready),
  .results_valid        (results.valid),
  .results_ready        (results.ready),
  .results_d_volt_cmd   (results.d_volt_cmd),
  .results_q_correction (results.q_correction)
);
